// File: hw/rtl/rqa_pkg.sv
// Shared types and constants for the RGB565 quad average to LCD write block.
package rqa_pkg;

    localparam int PIX_W     = 16;
    localparam int COORD_W   = 10;
    localparam int WIN_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam int BLUE_LSB  = 0;
    localparam int BLUE_W    = 5;
    localparam int GREEN_LSB = 5;
    localparam int GREEN_W   = 6;
    localparam int RED_LSB   = 11;
    localparam int RED_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 2'd1;

    localparam logic [WIN_W-1:0] COLUMN_OFFSET_RST = 16'd80;
    localparam logic [WIN_W-1:0] ROW_OFFSET_RST    = 16'd0;
    localparam logic [WIN_W-1:0] WIN_SPAN          = 16'd2;

    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEM_WRITE  = 8'h2C;

    localparam int SEQ_LEN = 19;
    localparam int IDX_W   = $clog2(SEQ_LEN);

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_top_left;
        logic [PIX_W-1:0]   pixel_top_right;
        logic [PIX_W-1:0]   pixel_bottom_left;
        logic [PIX_W-1:0]   pixel_bottom_right;
        logic [COORD_W-1:0] block_column;
        logic [COORD_W-1:0] block_row;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_data;
        logic              last_byte;
    } t_out_beat;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [WIN_W-1:0] col_start;
        logic [WIN_W-1:0] col_end;
        logic [WIN_W-1:0] row_start;
        logic [WIN_W-1:0] row_end;
    } t_job;

endpackage

// File: hw/rtl/rqa_lane.sv
// One color channel lane: sums four samples and registers the truncated quarter.
module rqa_lane
    import rqa_pkg::*;
#(
    parameter int CH_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [3:0][CH_W-1:0] i_ch,
    output logic [CH_W-1:0]      o_avg
);

    logic [CH_W+1:0] sum;
    logic [CH_W-1:0] r_avg;

    assign sum = {2'b00, i_ch[0]} + {2'b00, i_ch[1]}
               + {2'b00, i_ch[2]} + {2'b00, i_ch[3]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_avg <= sum[CH_W+1:2];
        end
    end

    assign o_avg = r_avg;

endmodule

// File: hw/rtl/rqa_merge.sv
// Merge stage: repacks the lane averages and forms the display window.
module rqa_merge
    import rqa_pkg::*;
(
    input  logic [BLUE_W-1:0]  i_blue,
    input  logic [GREEN_W-1:0] i_green,
    input  logic [RED_W-1:0]   i_red,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  logic [WIN_W-1:0]   i_col_off,
    input  logic [WIN_W-1:0]   i_row_off,
    output t_job               o_job,
    output logic               o_zero
);

    logic [WIN_W-1:0] col_start;
    logic [WIN_W-1:0] row_start;

    // window coordinates wrap at 16 bits
    assign col_start = i_col_off + {{(WIN_W-COORD_W){1'b0}}, i_col};
    assign row_start = i_row_off + {{(WIN_W-COORD_W){1'b0}}, i_row};

    assign o_job.pix       = {i_red, i_green, i_blue};
    assign o_job.col_start = col_start;
    assign o_job.col_end   = col_start + WIN_SPAN;
    assign o_job.row_start = row_start;
    assign o_job.row_end   = row_start + WIN_SPAN;
    assign o_zero          = (i_red == '0) && (i_green == '0) && (i_blue == '0);

endmodule

// File: hw/rtl/rqa_serializer.sv
// Byte sequencer: walks one window-and-pixel job out as nineteen beats.
module rqa_serializer
    import rqa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_job      i_job,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    localparam logic [IDX_W-1:0] IDX_COL_CMD  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_COL_S_HI = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_COL_S_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_COL_E_HI = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_COL_E_LO = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_ROW_CMD  = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_ROW_S_HI = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_ROW_S_LO = IDX_W'(7);
    localparam logic [IDX_W-1:0] IDX_ROW_E_HI = IDX_W'(8);
    localparam logic [IDX_W-1:0] IDX_ROW_E_LO = IDX_W'(9);
    localparam logic [IDX_W-1:0] IDX_MEM_CMD  = IDX_W'(10);
    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(SEQ_LEN - 1);

    logic             r_busy;
    logic             n_busy;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    t_job             r_job;
    logic             at_last;

    assign at_last = (r_idx == IDX_LAST);
    assign o_take  = !r_busy || (i_out_ready && at_last);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy && i_out_ready) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    always_comb begin
        o_out_beat.is_data   = 1'b1;
        o_out_beat.last_byte = at_last;
        unique case (r_idx)
            IDX_COL_CMD: begin
                o_out_beat.out_byte = CMD_COLUMN_SET;
                o_out_beat.is_data  = 1'b0;
            end
            IDX_COL_S_HI: o_out_beat.out_byte = r_job.col_start[15:8];
            IDX_COL_S_LO: o_out_beat.out_byte = r_job.col_start[7:0];
            IDX_COL_E_HI: o_out_beat.out_byte = r_job.col_end[15:8];
            IDX_COL_E_LO: o_out_beat.out_byte = r_job.col_end[7:0];
            IDX_ROW_CMD: begin
                o_out_beat.out_byte = CMD_ROW_SET;
                o_out_beat.is_data  = 1'b0;
            end
            IDX_ROW_S_HI: o_out_beat.out_byte = r_job.row_start[15:8];
            IDX_ROW_S_LO: o_out_beat.out_byte = r_job.row_start[7:0];
            IDX_ROW_E_HI: o_out_beat.out_byte = r_job.row_end[15:8];
            IDX_ROW_E_LO: o_out_beat.out_byte = r_job.row_end[7:0];
            IDX_MEM_CMD: begin
                o_out_beat.out_byte = CMD_MEM_WRITE;
                o_out_beat.is_data  = 1'b0;
            end
            // pixel beats: odd slots carry the low byte, even slots the high byte
            default: o_out_beat.out_byte = r_idx[0] ? r_job.pix[7:0] : r_job.pix[15:8];
        endcase
    end

    assign o_out_valid = r_busy;

endmodule

// File: hw/rtl/rgb565_quad_average_to_lcd_writes.sv
// Top level: 2x2 RGB565 box average feeding a display command and data byte stream.
//
//  channel   direction  handshake              payload
//  in        input      i_in_valid/o_in_ready  i_in_beat (t_in_beat)
//  out       output     o_out_valid/i_out_ready o_out_beat (t_out_beat)
//  cfg       input      i_cfg_we               i_cfg_index, i_cfg_data
//
// A block is registered in the lane registers; the merge stage then hands it to the
// byte sequencer once the sequencer can take it, or drops it when the average is zero.
// A nonzero block leaves as 19 beats, one per cycle while ready is high, so the output
// port sets the block rate; zero blocks are dropped without waiting for the sequencer.
// The next block is taken while the sequencer still sends the previous one.
// Reset is synchronous and clears valid state and the offsets to their defaults.
module rgb565_quad_average_to_lcd_writes
    import rqa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_beat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [WIN_W-1:0]   r_col_off;
    logic [WIN_W-1:0]   r_row_off;
    logic               r_a_valid;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;

    logic                       in_take;
    logic                       a_move;
    logic                       a_zero;
    logic                       ser_take;
    logic                       ser_load;
    t_job                       job;
    logic [3:0][PIX_W-1:0]      pix;
    logic [3:0][BLUE_W-1:0]     ch_blue;
    logic [3:0][GREEN_W-1:0]    ch_green;
    logic [3:0][RED_W-1:0]      ch_red;
    logic [BLUE_W-1:0]          avg_blue;
    logic [GREEN_W-1:0]         avg_green;
    logic [RED_W-1:0]           avg_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_off <= COLUMN_OFFSET_RST;
            r_row_off <= ROW_OFFSET_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_COLUMN_OFFSET) begin
                r_col_off <= i_cfg_data;
            end else if (i_cfg_index == REG_ROW_OFFSET) begin
                r_row_off <= i_cfg_data;
            end
        end
    end

    assign pix[0] = i_in_beat.pixel_top_left;
    assign pix[1] = i_in_beat.pixel_top_right;
    assign pix[2] = i_in_beat.pixel_bottom_left;
    assign pix[3] = i_in_beat.pixel_bottom_right;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ch_blue[k]  = pix[k][BLUE_LSB  +: BLUE_W];
            ch_green[k] = pix[k][GREEN_LSB +: GREEN_W];
            ch_red[k]   = pix[k][RED_LSB   +: RED_W];
        end
    end

    // drop zero blocks at once, otherwise wait for the sequencer
    assign a_move     = r_a_valid && (a_zero || ser_take);
    assign ser_load   = r_a_valid && !a_zero && ser_take;
    assign o_in_ready = !r_a_valid || a_move;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_col <= i_in_beat.block_column;
            r_row <= i_in_beat.block_row;
        end
    end

    rqa_lane #(.CH_W(BLUE_W)) u_lane_blue (
        .i_clk (i_clk),
        .i_en  (in_take),
        .i_ch  (ch_blue),
        .o_avg (avg_blue)
    );

    rqa_lane #(.CH_W(GREEN_W)) u_lane_green (
        .i_clk (i_clk),
        .i_en  (in_take),
        .i_ch  (ch_green),
        .o_avg (avg_green)
    );

    rqa_lane #(.CH_W(RED_W)) u_lane_red (
        .i_clk (i_clk),
        .i_en  (in_take),
        .i_ch  (ch_red),
        .o_avg (avg_red)
    );

    rqa_merge u_merge (
        .i_blue    (avg_blue),
        .i_green   (avg_green),
        .i_red     (avg_red),
        .i_col     (r_col),
        .i_row     (r_row),
        .i_col_off (r_col_off),
        .i_row_off (r_row_off),
        .o_job     (job),
        .o_zero    (a_zero)
    );

    rqa_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (ser_load),
        .i_job       (job),
        .o_take      (ser_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

// File: hw/rtl/rqa_checker.sv
// Port-level checker for the quad average block, bound to the top level.
module rqa_checker
    import rqa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // input backs up only while the sequencer has bytes to send
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |-> o_out_valid)
        else $error("input stalled with output idle");

    // a new sequence opens with the column set command
    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_beat.last_byte |=>
        !o_out_valid || (!o_out_beat.is_data && o_out_beat.out_byte == CMD_COLUMN_SET))
        else $error("sequence did not start with column set");

    // last byte is always a data byte
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.last_byte |-> o_out_beat.is_data)
        else $error("last byte not a data byte");

endmodule

bind rgb565_quad_average_to_lcd_writes rqa_checker u_rqa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

// File: verif/rgb565_quad_average_to_lcd_writes_tb.sv
// Self-checking testbench for the RGB565 2x2 average to LCD write sequencer.
module rgb565_quad_average_to_lcd_writes_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rqa_pkg::*;

    // indexes the block decodes to nothing; writes there must not land
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int DRAIN_LIMIT   = 50000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_beat             i_in_beat = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_beat            o_out_beat;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    rgb565_quad_average_to_lcd_writes u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_beat   block_q[$];
    t_out_beat  lcd_bytes_q[$];
    logic [WIN_W-1:0] col_offset_copy = COLUMN_OFFSET_RST;
    logic [WIN_W-1:0] row_offset_copy = ROW_OFFSET_RST;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       in_beat_taken = 1'b0;
    int         mismatches = 0;
    int         blocks_accepted = 0;
    int         dark_blocks = 0;
    int         bytes_checked = 0;
    t_in_beat   next_block;
    t_out_beat  want_beat;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic void push_lcd_byte(input logic [BYTE_W-1:0] val, input logic is_data,
                                          input logic is_last);
        t_out_beat b;
        b.out_byte  = val;
        b.is_data   = is_data;
        b.last_byte = is_last;
        lcd_bytes_q.push_back(b);
    endfunction

    // Average the four pixels per channel and, unless the average is zero, queue the window/pixel byte sequence.
    function automatic void queue_lcd_writes(input t_in_beat blk);
        logic [PIX_W-1:0] px[4];
        logic [7:0]       sum_b;
        logic [7:0]       sum_g;
        logic [7:0]       sum_r;
        logic [PIX_W-1:0] avg;
        logic [WIN_W-1:0] cs;
        logic [WIN_W-1:0] ce;
        logic [WIN_W-1:0] rs;
        logic [WIN_W-1:0] re;
        px[0] = blk.pixel_top_left;
        px[1] = blk.pixel_top_right;
        px[2] = blk.pixel_bottom_left;
        px[3] = blk.pixel_bottom_right;
        sum_b = '0;
        sum_g = '0;
        sum_r = '0;
        for (int k = 0; k < 4; k++) begin
            sum_b += 8'(px[k][BLUE_LSB +: BLUE_W]);
            sum_g += 8'(px[k][GREEN_LSB +: GREEN_W]);
            sum_r += 8'(px[k][RED_LSB +: RED_W]);
        end
        avg = {sum_r[6:2], sum_g[7:2], sum_b[6:2]};
        blocks_accepted++;
        if (avg == '0) begin
            dark_blocks++;
            return;
        end
        cs = col_offset_copy + WIN_W'(blk.block_column);
        ce = cs + WIN_SPAN;
        rs = row_offset_copy + WIN_W'(blk.block_row);
        re = rs + WIN_SPAN;
        push_lcd_byte(CMD_COLUMN_SET, 1'b0, 1'b0);
        push_lcd_byte(cs[15:8], 1'b1, 1'b0);
        push_lcd_byte(cs[7:0], 1'b1, 1'b0);
        push_lcd_byte(ce[15:8], 1'b1, 1'b0);
        push_lcd_byte(ce[7:0], 1'b1, 1'b0);
        push_lcd_byte(CMD_ROW_SET, 1'b0, 1'b0);
        push_lcd_byte(rs[15:8], 1'b1, 1'b0);
        push_lcd_byte(rs[7:0], 1'b1, 1'b0);
        push_lcd_byte(re[15:8], 1'b1, 1'b0);
        push_lcd_byte(re[7:0], 1'b1, 1'b0);
        push_lcd_byte(CMD_MEM_WRITE, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++) begin
            push_lcd_byte(avg[7:0], 1'b1, 1'b0);
            push_lcd_byte(avg[15:8], 1'b1, k == 3);
        end
    endfunction

    // Driver: hold the beat until taken, then present the next one or idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat_taken) begin
            if (block_q.size() != 0 &&
                !(send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)) begin
                next_block = block_q.pop_front();
                i_in_beat  <= next_block;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on input beats, check output beats against the oldest byte.
    always @(posedge i_clk) begin
        in_beat_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            queue_lcd_writes(i_in_beat);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lcd_bytes_q.size() == 0) begin
                report_mismatch("unexpected byte", o_out_beat, 0);
            end else begin
                want_beat = lcd_bytes_q.pop_front();
                bytes_checked++;
                if (o_out_beat.out_byte !== want_beat.out_byte)
                    report_mismatch("out_byte", o_out_beat.out_byte, want_beat.out_byte);
                if (o_out_beat.is_data !== want_beat.is_data)
                    report_mismatch("is_data", o_out_beat.is_data, want_beat.is_data);
                if (o_out_beat.last_byte !== want_beat.last_byte)
                    report_mismatch("last_byte", o_out_beat.last_byte, want_beat.last_byte);
            end
        end
    end

    task automatic add_block(input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] tr,
                             input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] br,
                             input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        t_in_beat b;
        b.pixel_top_left     = tl;
        b.pixel_top_right    = tr;
        b.pixel_bottom_left  = bl;
        b.pixel_bottom_right = br;
        b.block_column       = col;
        b.block_row          = row;
        block_q.push_back(b);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int kind);
        case (kind)
            0: return {5'($urandom_range(1)), 6'($urandom_range(3)), 5'($urandom_range(3))};
            1: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int kind);
        if (kind == 1) begin
            case ($urandom_range(2))
                0: return '0;
                1: return '1;
                default: return COORD_W'($urandom);
            endcase
        end
        return COORD_W'($urandom);
    endfunction

    // Mostly full-range pixels; some dark blocks that average near zero; some extremes.
    task automatic add_random_blocks(input int n);
        int roll;
        int kind;
        repeat (n) begin
            roll = $urandom_range(99);
            kind = (roll < 70) ? 2 : (roll < 85) ? 0 : 1;
            add_block(pick_pixel(kind), pick_pixel(kind), pick_pixel(kind), pick_pixel(kind),
                      pick_coord(kind), pick_coord(kind));
        end
    endtask

    task automatic settle();
        while (block_q.size() != 0 || i_in_valid || lcd_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_COLUMN_OFFSET: col_offset_copy = val;
            REG_ROW_OFFSET:    row_offset_copy = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Split each phase with a full drain so the sender sits idle until the output is empty.
    task automatic run_phase(input int n, input int s_pct, input int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        add_random_blocks(n / 2);
        settle();
        add_random_blocks(n - n / 2);
        settle();
    endtask

    initial begin
        int guard;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, single channels, truncation to zero, one hot positions
        add_block(16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0);
        add_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023);
        add_block(16'h001F, 16'h001F, 16'h001F, 16'h001F, 10'd0, 10'd1023);
        add_block(16'h07E0, 16'h07E0, 16'h07E0, 16'h07E0, 10'd1023, 10'd0);
        add_block(16'hF800, 16'hF800, 16'hF800, 16'hF800, 10'd5, 10'd7);
        add_block(16'h0001, 16'h0001, 16'h0001, 16'h0000, 10'd1, 10'd1);
        add_block(16'h0821, 16'h0821, 16'h0821, 16'h0000, 10'd2, 10'd3);
        add_block(16'h0821, 16'h0821, 16'h0821, 16'h0821, 10'd2, 10'd3);
        add_block(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 10'd100, 10'd200);
        add_block(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 10'd511, 10'd512);
        add_block(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 10'd256, 10'd768);
        add_block(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 10'd682, 10'd341);
        add_block(16'h0100, 16'h0100, 16'h0100, 16'h0100, 10'd3, 10'd4);
        add_block(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 10'd4, 10'd3);
        add_block(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 10'd341, 10'd682);
        add_block(16'h0003, 16'h0000, 16'h0000, 16'h0000, 10'd9, 10'd9);
        run_phase(70, 0, 0);

        write_reg(REG_COLUMN_OFFSET, 16'h0000);
        write_reg(REG_ROW_OFFSET, 16'h0000);
        end_writes();
        run_phase(95, 54, 0);

        // window start and end wrap past 65535
        write_reg(REG_COLUMN_OFFSET, 16'hFFFF);
        write_reg(REG_ROW_OFFSET, 16'hFFFF);
        end_writes();
        run_phase(95, 0, 54);

        write_reg(REG_COLUMN_OFFSET, CFG_W'($urandom));
        write_reg(REG_ROW_OFFSET, CFG_W'($urandom));
        write_reg(REG_SPARE_A, CFG_W'($urandom));
        write_reg(REG_SPARE_B, CFG_W'($urandom));
        end_writes();
        run_phase(95, 26, 26);

        write_reg(REG_COLUMN_OFFSET, 16'hFC00 + CFG_W'($urandom_range(1023)));
        write_reg(REG_ROW_OFFSET, 16'hFFFE);
        end_writes();
        run_phase(95, 0, 0);

        guard = 0;
        while ((block_q.size() != 0 || i_in_valid || lcd_bytes_q.size() != 0) &&
               guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (lcd_bytes_q.size() != 0)
            report_mismatch("bytes never sent", lcd_bytes_q.size(), 0);

        $display("Covered %0d blocks (%0d averaging to zero), %0d LCD bytes compared,",
                 blocks_accepted, dark_blocks, bytes_checked);
        $display("over five offset settings with wraparound and four idle/stall mixes.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout: stimulus or output did not drain");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
